// File: rtl/core/dqks_pkg.sv
// Shared types and constants for the deque with key search.
// No dependencies; every other file in rtl/core imports this package.
package dqks_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 40;
    localparam int TUSER_OUT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_REM_HEAD = 3'd2,
        CMD_REM_TAIL = 3'd3,
        CMD_SEARCH   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // shift_fwd: every cell takes its successor (toward the head)
    // shift_bwd: every cell takes its predecessor (away from the head)
    typedef struct packed {
        logic shift_fwd;
        logic shift_bwd;
    } cell_ctl_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  out_value;
        logic                      found;
        logic [POS_W-1:0]          position;
    } result_t;

endpackage

// File: rtl/core/dqks_cell.sv
// One storage cell of the deque ring: a word register that loads from either neighbor.
// Depends on dqks_pkg.
module dqks_cell (
    input  logic                               clk,
    input  dqks_pkg::cell_ctl_t                ctl,
    input  logic signed [dqks_pkg::DATA_W-1:0] from_prev,
    input  logic signed [dqks_pkg::DATA_W-1:0] from_next,
    output logic signed [dqks_pkg::DATA_W-1:0] data
);
    import dqks_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        priority if (ctl.shift_fwd)
        begin
            data_next = from_next;
        end
        else if (ctl.shift_bwd)
        begin
            data_next = from_prev;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/core/deque_with_key_search.sv
// Channel | Dir | tdata                          | tuser
// s       | in  | [31:0] value                   | [2:0] cmd
// m       | out | [31:0] out_value, [38:32] pos  | [1:0] status, [2] found
//
// Head insert, head remove, unused codes and any command that fails on an empty or full
// queue finish in the cycle the request is accepted. Tail insert, tail remove and search
// go on in ST_WALK while the cell ring makes one full revolution past cell 0.
// One request is in work at a time; a new one is taken once the result register is free
// or being drained. Reset (rst_n, async, low) empties the queue; cell contents are unset.
// Top level of the deque; depends on dqks_pkg and dqks_cell.
module deque_with_key_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dqks_pkg::TDATA_IN_W-1:0]     s_tdata,   // [31:0] value
    input  logic [dqks_pkg::CMD_W-1:0]          s_tuser,   // [2:0] cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dqks_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [31:0] out_value, [38:32] position
    output logic [dqks_pkg::TUSER_OUT_W-1:0]    m_tuser    // [1:0] status, [2] found
);
    import dqks_pkg::*;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_prev [CAPACITY];
    logic signed [DATA_W-1:0] cell_succ [CAPACITY];
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] feed;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    cmd_t                     op_reg, op_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     hit_reg, hit_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] tailv_reg, tailv_next;
    result_t                  res_reg, res_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    cmd_t                     cmd;
    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic                     start_walk;
    logic                     last_step;
    logic [CNT_W-1:0]         step_ext;

    assign cmd        = cmd_t'(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign start_walk = accept && (((cmd == CMD_INS_TAIL) && !is_full) ||
                                   ((cmd == CMD_REM_TAIL) && !is_empty) ||
                                   ((cmd == CMD_SEARCH)   && !is_empty));
    assign step_ext   = CNT_W'(step_reg);
    assign last_step  = (step_reg == IDX_W'(CAPACITY - 1));

    // ring of cells, cell 0 holds the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign cell_prev[i] = s_tdata;
        end
        else
        begin : g_prev
            assign cell_prev[i] = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign cell_succ[i] = feed;
        end
        else
        begin : g_succ
            assign cell_succ[i] = cell_data[i+1];
        end

        dqks_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .from_prev (cell_prev[i]),
            .from_next (cell_succ[i]),
            .data      (cell_data[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        feed          = cell_data[0];
        count_next    = count_reg;
        step_next     = step_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        tailv_next    = tailv_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (accept)
        begin
            res_next        = '0;
            res_next.status = STAT_OK;
            m_tvalid_next   = 1'b1;
            step_next       = '0;
            op_next         = cmd;
            key_next        = s_tdata;
            hit_next        = 1'b0;
            pos_next        = '0;
            tailv_next      = '0;
            unique case (cmd)
                CMD_INS_HEAD:
                begin
                    if (is_full)
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        ctl.shift_bwd = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                CMD_INS_TAIL:
                begin
                    if (is_full)
                    begin
                        res_next.status = STAT_FULL;
                    end
                    else
                    begin
                        m_tvalid_next = 1'b0;
                    end
                end
                CMD_REM_HEAD:
                begin
                    if (is_empty)
                    begin
                        res_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        res_next.out_value = cell_data[0];
                        ctl.shift_fwd      = 1'b1;
                        count_next         = count_reg - CNT_W'(1);
                    end
                end
                CMD_REM_TAIL:
                begin
                    if (is_empty)
                    begin
                        res_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        m_tvalid_next = 1'b0;
                    end
                end
                CMD_SEARCH:
                begin
                    res_next.out_value = s_tdata;
                    if (is_empty)
                    begin
                        res_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        m_tvalid_next = 1'b0;
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
        else if (state_reg == ST_WALK)
        begin
            // rotate one slot: cell 0 holds entry step_reg in this cycle
            ctl.shift_fwd = 1'b1;
            if ((op_reg == CMD_INS_TAIL) && (step_ext == count_reg))
            begin
                feed = key_reg;
            end
            if ((op_reg == CMD_REM_TAIL) && (step_ext == count_reg - CNT_W'(1)))
            begin
                tailv_next = cell_data[0];
            end
            if ((op_reg == CMD_SEARCH) && !hit_reg && (step_ext < count_reg) &&
                (cell_data[0] == key_reg))
            begin
                hit_next = 1'b1;
                pos_next = POS_W'(step_ext + CNT_W'(1));
            end
            step_next = step_reg + IDX_W'(1);

            if (last_step)
            begin
                res_next        = '0;
                res_next.status = STAT_OK;
                m_tvalid_next   = 1'b1;
                unique case (op_reg)
                    CMD_INS_TAIL:
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    CMD_REM_TAIL:
                    begin
                        res_next.out_value = tailv_next;
                        count_next         = count_reg - CNT_W'(1);
                    end
                    CMD_SEARCH:
                    begin
                        res_next.out_value = key_reg;
                        res_next.found     = hit_next;
                        res_next.position  = pos_next;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        hit_reg   <= hit_next;
        pos_reg   <= pos_next;
        tailv_reg <= tailv_next;
        res_reg   <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.position, res_reg.out_value};
    assign m_tuser  = {res_reg.found, res_reg.status};

endmodule

// File: rtl/core/dqks_checker.sv
// Port-level checks for the deque with key search, bound to the top level.
// Depends on dqks_pkg and deque_with_key_search.
module dqks_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [dqks_pkg::TDATA_IN_W-1:0]     s_tdata,
    input logic [dqks_pkg::CMD_W-1:0]          s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dqks_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input logic [dqks_pkg::TUSER_OUT_W-1:0]    m_tuser
);
    import dqks_pkg::*;

    // a waiting result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no new request while the result register is blocked
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("request taken over a stalled result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser[1:0] == STAT_OK) || (m_tuser[1:0] == STAT_EMPTY) ||
                      (m_tuser[1:0] == STAT_FULL)))
        else $error("undefined status code");

    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tdata[38:32] != '0) && (m_tuser[1:0] == STAT_OK))
        else $error("match without position or with bad status");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> (m_tdata[38:32] == '0))
        else $error("position set without a match");

endmodule

bind deque_with_key_search dqks_checker u_dqks_checker (.*);

// File: dv/deque_with_key_search_test.sv
// Self-checking testbench for deque_with_key_search: directed and random command streams.
// Depends on dqks_pkg and the deque RTL; holds its own deque model for the expected replies.
module deque_with_key_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dqks_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [TDATA_IN_W-1:0]     s_tdata;
    logic [CMD_W-1:0]          s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [TDATA_OUT_W-1:0]    m_tdata;
    logic [TUSER_OUT_W-1:0]    m_tuser;

    // deque model: slots, head slot and number of stored words
    logic signed [DATA_W-1:0]  slots [CAPACITY];
    int                        head_slot;
    int                        fill;

    result_t                   awaited_replies [$];
    int                        errors;
    int                        cycle_count;
    int                        hold_request;
    bit                        idle_off;

    deque_with_key_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one command to the deque model and return the reply it must produce.
    function automatic result_t apply_command(input logic [CMD_W-1:0] op,
                                              input logic signed [DATA_W-1:0] word);
        result_t reply;
        int i;
        reply = '0;
        unique case (op)
            CMD_INS_HEAD:
                if (fill >= CAPACITY)
                    reply.status = STAT_FULL;
                else
                begin
                    head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                    slots[head_slot] = word;
                    fill++;
                end
            CMD_INS_TAIL:
                if (fill >= CAPACITY)
                    reply.status = STAT_FULL;
                else
                begin
                    slots[(head_slot + fill) % CAPACITY] = word;
                    fill++;
                end
            CMD_REM_HEAD:
                if (fill == 0)
                    reply.status = STAT_EMPTY;
                else
                begin
                    reply.out_value = slots[head_slot];
                    head_slot = (head_slot + 1) % CAPACITY;
                    fill--;
                end
            CMD_REM_TAIL:
                if (fill == 0)
                    reply.status = STAT_EMPTY;
                else
                begin
                    reply.out_value = slots[(head_slot + fill - 1) % CAPACITY];
                    fill--;
                end
            CMD_SEARCH:
            begin
                reply.out_value = word;
                if (fill == 0)
                    reply.status = STAT_EMPTY;
                else
                    for (i = 0; i < fill; i++)
                        if (!reply.found && slots[(head_slot + i) % CAPACITY] == word)
                        begin
                            reply.found = 1'b1;
                            reply.position = POS_W'(i + 1);
                        end
            end
            default: ;
        endcase
        return reply;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 50);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        else if (r < 7)
            return DATA_W'($urandom_range(0, 7)) - 4;
        else if (r < 8)
            unique case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return '0;
                default: return '1;
            endcase
        else
            return $urandom;
    endfunction

    // Favor keys that are stored: half of the time a stored key is drawn, so that many searches hit.
    function automatic logic signed [DATA_W-1:0] pick_key();
        if (fill > 0 && $urandom_range(0, 1))
            return slots[(head_slot + $urandom_range(0, fill - 1)) % CAPACITY];
        return pick_word();
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (s_tvalid && s_tready)
            awaited_replies.push_back(apply_command(s_tuser, s_tdata));
        if (m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with no request outstanding: expected none,",
                         $time, " got tdata %h tuser %h", m_tdata, m_tuser);
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", want.status, m_tuser[1:0]);
                check_field("out_value", want.out_value, $signed(m_tdata[31:0]));
                check_field("found", want.found, m_tuser[2]);
                check_field("position", want.position, m_tdata[38:32]);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!idle_off && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // Offer one request after a random gap and hold it until it is taken.
    task automatic issue_command(input logic [CMD_W-1:0] op,
                                 input logic signed [DATA_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic test_empty_queue();
        int k;
        issue_command(CMD_REM_HEAD, pick_word());
        issue_command(CMD_REM_TAIL, pick_word());
        issue_command(CMD_SEARCH, pick_word());
        for (k = CMD_FIRST_UNUSED; k <= CMD_LAST_CODE; k++)
            issue_command(CMD_W'(k), pick_word());
    endtask

    task automatic test_word_extremes();
        issue_command(CMD_INS_HEAD, 32'h7fff_ffff);
        issue_command(CMD_INS_TAIL, 32'h8000_0000);
        issue_command(CMD_INS_HEAD, '0);
        issue_command(CMD_INS_TAIL, '1);
        issue_command(CMD_SEARCH, 32'h8000_0000);
        issue_command(CMD_SEARCH, '1);
        issue_command(CMD_SEARCH, '0);
        issue_command(CMD_SEARCH, 32'h0001_2345);
        // duplicate at the head: search must report the first match
        issue_command(CMD_INS_HEAD, 32'h7fff_ffff);
        issue_command(CMD_SEARCH, 32'h7fff_ffff);
        issue_command(CMD_REM_TAIL, pick_word());
        issue_command(CMD_REM_HEAD, pick_word());
        issue_command(CMD_REM_HEAD, pick_word());
        issue_command(CMD_REM_TAIL, pick_word());
        issue_command(CMD_REM_HEAD, pick_word());
    endtask

    task automatic test_full_with_backpressure();
        logic signed [DATA_W-1:0] base;
        int i;
        base = $urandom;
        idle_off = 1'b1;
        hold_request = 300;
        for (i = 0; i < CAPACITY - 1; i++)
            issue_command($urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD, base + i);
        issue_command(CMD_INS_TAIL, base + CAPACITY - 1);
        issue_command(CMD_INS_HEAD, pick_word());
        issue_command(CMD_INS_TAIL, pick_word());
        // unique tail word sits at the deepest position
        issue_command(CMD_SEARCH, base + CAPACITY - 1);
        issue_command(CMD_SEARCH, base + CAPACITY);
        idle_off = 1'b0;
        for (i = 0; i <= CAPACITY; i++)
            issue_command((i % 2) ? CMD_REM_TAIL : CMD_REM_HEAD, pick_word());
    endtask

    task automatic test_random_traffic(input int target);
        int useful;
        int r;
        bit grow;
        logic [CMD_W-1:0] op;
        useful = 0;
        grow = 1'b1;
        while (useful < target)
        begin
            idle_off = (useful % 200) >= 170;
            if (fill == CAPACITY && $urandom_range(0, 99) < 30)
                grow = 1'b0;
            else if (fill == 0 && $urandom_range(0, 99) < 30)
                grow = 1'b1;
            else if ($urandom_range(0, 99) < 1)
                grow = !grow;
            r = $urandom_range(0, 99);
            if (r < 4)
                op = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
            else if (r < 30)
                op = CMD_SEARCH;
            else if ((r < 78) == grow)
                op = $urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD;
            else
                op = $urandom_range(0, 1) ? CMD_REM_TAIL : CMD_REM_HEAD;
            issue_command(op, (op == CMD_SEARCH) ? pick_key() : pick_word());
            if (op <= CMD_SEARCH)
                useful++;
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        head_slot = 0;
        fill = 0;
        errors = 0;
        cycle_count = 0;
        hold_request = 0;
        idle_off = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue();
        test_word_extremes();
        test_full_with_backpressure();
        test_random_traffic(800);

        s_tvalid <= 1'b0;
        wait (awaited_replies.size() == 0);
        repeat (2 * CAPACITY) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
